// ===== rtl/a2i_pkg.sv =====
// Package for the 2D affine inverse: constants, status codes and payload types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package a2i_pkg;
    localparam int A2I_FRAC   = 16;
    localparam int A2I_W      = 32;
    localparam int A2I_NW     = A2I_W + 2 * A2I_FRAC;
    localparam int A2I_QB     = 33;
    localparam int A2I_DIVLAT = A2I_QB + 1;
    localparam int A2I_LAT    = A2I_DIVLAT + 5;
    localparam int A2I_MINW   = 31;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SING = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [A2I_W-1:0] m00;
        logic signed [A2I_W-1:0] m01;
        logic signed [A2I_W-1:0] m10;
        logic signed [A2I_W-1:0] m11;
        logic signed [A2I_W-1:0] shift_x;
        logic signed [A2I_W-1:0] shift_y;
    } t_in;

    typedef struct packed {
        logic signed [A2I_W-1:0] inv00;
        logic signed [A2I_W-1:0] inv01;
        logic signed [A2I_W-1:0] inv10;
        logic signed [A2I_W-1:0] inv11;
        logic signed [A2I_W-1:0] inv_shift_x;
        logic signed [A2I_W-1:0] inv_shift_y;
        t_status                 status;
    } t_out;
endpackage
`default_nettype wire

// ===== rtl/a2i_div.sv =====
// Pipelined restoring divider: trunc(nmag * 2^(2F) / dmag), one quotient bit per stage.
// Depends on a2i_pkg.
`timescale 1ns / 1ps
`default_nettype none
module a2i_div (
    input  wire logic                         i_clk,
    input  wire logic [a2i_pkg::A2I_W-1:0]    i_nmag,
    input  wire logic [63:0]                  i_dmag,
    output logic      [a2i_pkg::A2I_QB-1:0]   o_q,
    output logic                              o_big
);
    import a2i_pkg::*;

    logic [A2I_NW-1:0] w_num;
    logic [63:0]       w_top;
    logic [63:0]       r_rem  [0:A2I_QB];
    logic [63:0]       r_dmag [0:A2I_QB];
    logic [A2I_QB-1:0] r_low  [0:A2I_QB];
    logic [A2I_QB-1:0] r_q    [0:A2I_QB];
    logic              r_big  [0:A2I_QB];

    assign w_num = {i_nmag, {(2 * A2I_FRAC){1'b0}}};
    assign w_top = 64'(w_num >> A2I_QB);

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= w_top;
        r_dmag[0] <= i_dmag;
        r_low[0]  <= w_num[A2I_QB-1:0];
        r_q[0]    <= '0;
        r_big[0]  <= (w_top >= i_dmag);
    end

    for (genvar k = 1; k <= A2I_QB; k++) begin : g_stage
        logic [64:0] w_t;
        logic        w_ge;
        always_comb begin
            w_t  = {r_rem[k-1], r_low[k-1][A2I_QB-k]};
            w_ge = (w_t >= {1'b0, r_dmag[k-1]});
        end
        always_ff @(posedge i_clk) begin
            r_rem[k]  <= w_ge ? 64'(w_t - {1'b0, r_dmag[k-1]}) : w_t[63:0];
            r_dmag[k] <= r_dmag[k-1];
            r_low[k]  <= r_low[k-1];
            r_q[k]    <= {r_q[k-1][A2I_QB-2:0], w_ge};
            r_big[k]  <= r_big[k-1];
        end
    end

    assign o_q   = r_q[A2I_QB];
    assign o_big = r_big[A2I_QB];
endmodule
`default_nettype wire

// ===== rtl/affine_2d_inverse.sv =====
// Top level of the 2D affine inverse: determinant, four dividers, translation terms.
// Depends on a2i_pkg and a2i_div.
//
//   channel   | ports                                  | transfer
//   ----------+----------------------------------------+------------------------------
//   input     | i_start, o_busy, i_item                | i_start high, o_busy low
//   result    | o_valid, o_result                      | o_valid high, one cycle
//   config    | psel, penable, pwrite, paddr, pwdata,  | psel, penable, pwrite, pready
//             | prdata, pready                         |
//
// One transform enters per cycle outside reset; each result passes the determinant,
// the 33-stage quotient pipeline of the dividers and the translation stage.
// o_busy is high only in reset; the receiver cannot stall, so nothing ever holds.
// Synchronous active-low reset clears all valid bits and min_abs_det.
`timescale 1ns / 1ps
`default_nettype none
module affine_2d_inverse (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    output logic                 o_busy,
    input  wire a2i_pkg::t_in    i_item,
    output logic                 o_valid,
    output a2i_pkg::t_out        o_result,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [2:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic      [31:0]     prdata,
    output logic                 pready
);
    import a2i_pkg::*;

    typedef struct packed {
        logic [3:0]              nneg;
        logic                    dneg;
        logic                    sing;
        logic signed [A2I_W-1:0] tx;
        logic signed [A2I_W-1:0] ty;
    } t_side;

    logic [A2I_MINW-1:0] r_min;

    // determinant products
    logic                    r1_v;
    t_in                     r1_in;
    logic signed [63:0]      r1_pa;
    logic signed [63:0]      r1_pb;

    // determinant magnitude and numerators
    logic                    r2_v;
    t_side                   r2_sd;
    logic [63:0]             r2_dmag;
    logic [A2I_W-1:0]        r2_nmag [0:3];

    logic                    r_dv [0:A2I_QB];
    t_side                   r_sd [0:A2I_QB];
    logic [A2I_QB-1:0]       w_q   [0:3];
    logic                    w_big [0:3];

    logic                    r3_v;
    logic                    r3_ok;
    t_side                   r3_sd;
    logic signed [A2I_W-1:0] r3_inv [0:3];
    logic signed [A2I_W-1:0] n3_inv [0:3];
    logic                    n3_ok;

    logic                    r4_v;
    logic                    r4_ok;
    logic                    r4_sing;
    logic signed [A2I_W-1:0] r4_inv [0:3];
    logic signed [63:0]      r4_p [0:3];

    logic                    r_vo;
    t_out                    r_out;
    t_out                    n_out;

    logic [63:0]             w_dmag;
    logic                    w_pge;
    logic signed [65:0]      w_s [0:1];
    logic [65:0]             w_mag [0:1];
    logic [65:0]             w_sh [0:1];
    logic                    w_fit [0:1];
    logic signed [A2I_W-1:0] w_tv [0:1];

    function automatic logic [A2I_W-1:0] f_mag(input logic signed [A2I_W-1:0] v);
        f_mag = v[A2I_W-1] ? A2I_W'(-v) : v;
    endfunction

    assign o_busy = !i_rst_n;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {1'b0, r_min} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_min <= pwdata[A2I_MINW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_in <= i_item;
        r1_pa <= i_item.m00 * i_item.m11;
        r1_pb <= i_item.m01 * i_item.m10;
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_start;
        end
    end

    assign w_pge  = (r1_pa >= r1_pb);
    assign w_dmag = w_pge ? 64'(r1_pa - r1_pb) : 64'(r1_pb - r1_pa);

    always_ff @(posedge i_clk) begin
        r2_dmag    <= w_dmag;
        r2_nmag[0] <= f_mag(r1_in.m11);
        r2_nmag[1] <= f_mag(r1_in.m01);
        r2_nmag[2] <= f_mag(r1_in.m10);
        r2_nmag[3] <= f_mag(r1_in.m00);
        r2_sd.nneg <= {r1_in.m00[A2I_W-1],
                       !r1_in.m10[A2I_W-1] && r1_in.m10 != '0,
                       !r1_in.m01[A2I_W-1] && r1_in.m01 != '0,
                       r1_in.m11[A2I_W-1]};
        r2_sd.dneg <= !w_pge;
        r2_sd.sing <= (w_dmag <= 64'({r_min, {A2I_FRAC{1'b0}}}));
        r2_sd.tx   <= r1_in.shift_x;
        r2_sd.ty   <= r1_in.shift_y;
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    for (genvar t = 0; t < 4; t++) begin : g_div
        a2i_div u_div (
            .i_clk  (i_clk),
            .i_nmag (r2_nmag[t]),
            .i_dmag (r2_dmag),
            .o_q    (w_q[t]),
            .o_big  (w_big[t])
        );
    end

    always_ff @(posedge i_clk) begin
        r_sd[0] <= r2_sd;
        for (int k = 1; k <= A2I_QB; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
        if (!i_rst_n) begin
            for (int k = 0; k <= A2I_QB; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else begin
            r_dv[0] <= r2_v;
            for (int k = 1; k <= A2I_QB; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    always_comb begin
        logic neg;
        n3_ok = 1'b1;
        for (int t = 0; t < 4; t++) begin
            neg = r_sd[A2I_QB].nneg[t] ^ r_sd[A2I_QB].dneg;
            n3_inv[t] = neg ? A2I_W'(-w_q[t]) : w_q[t][A2I_W-1:0];
            if (w_big[t]) begin
                n3_ok = 1'b0;
            end else if (neg && w_q[t] > {2'b01, {(A2I_QB-2){1'b0}}}) begin
                n3_ok = 1'b0;
            end else if (!neg && w_q[t] > {2'b00, {(A2I_QB-2){1'b1}}}) begin
                n3_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r3_inv <= n3_inv;
        r3_ok  <= n3_ok;
        r3_sd  <= r_sd[A2I_QB];
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r_dv[A2I_QB];
        end
    end

    always_ff @(posedge i_clk) begin
        r4_p[0] <= r3_inv[0] * r3_sd.tx;
        r4_p[1] <= r3_inv[1] * r3_sd.ty;
        r4_p[2] <= r3_inv[2] * r3_sd.tx;
        r4_p[3] <= r3_inv[3] * r3_sd.ty;
        r4_inv  <= r3_inv;
        r4_ok   <= r3_ok;
        r4_sing <= r3_sd.sing;
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
    end

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            w_s[j]   = -($signed({{2{r4_p[2*j][63]}}, r4_p[2*j]})
                       + $signed({{2{r4_p[2*j+1][63]}}, r4_p[2*j+1]}));
            w_mag[j] = w_s[j][65] ? 66'(-w_s[j]) : w_s[j];
            w_sh[j]  = w_mag[j] >> A2I_FRAC;
            w_fit[j] = w_s[j][65] ? (w_sh[j] <= 66'h0_8000_0000)
                                  : (w_sh[j] <= 66'h0_7FFF_FFFF);
            w_tv[j]  = w_s[j][65] ? A2I_W'(-w_sh[j]) : w_sh[j][A2I_W-1:0];
        end
        n_out = '0;
        if (r4_sing) begin
            n_out.status = ST_SING;
        end else if (r4_ok && w_fit[0] && w_fit[1]) begin
            n_out.status      = ST_OK;
            n_out.inv00       = r4_inv[0];
            n_out.inv01       = r4_inv[1];
            n_out.inv10       = r4_inv[2];
            n_out.inv11       = r4_inv[3];
            n_out.inv_shift_x = w_tv[0];
            n_out.inv_shift_y = w_tv[1];
        end else begin
            n_out.status = ST_OVF;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r4_v;
        end
    end

    assign o_valid  = r_vo;
    assign o_result = r_out;
endmodule
`default_nettype wire

// ===== rtl/a2i_chk.sv =====
// Port checker for affine_2d_inverse, with its bind statement.
// Depends on a2i_pkg.
`timescale 1ns / 1ps
`default_nettype none
module a2i_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_start,
    input wire logic          o_busy,
    input wire logic          o_valid,
    input wire a2i_pkg::t_out o_result
);
    import a2i_pkg::*;

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, A2I_LAT)) else $error("result without transfer");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.status == ST_OK || o_result.status == ST_SING
                     || o_result.status == ST_OVF)) else $error("bad status");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_OK) |->
        (o_result.inv00 == 0 && o_result.inv01 == 0 && o_result.inv10 == 0
         && o_result.inv11 == 0 && o_result.inv_shift_x == 0
         && o_result.inv_shift_y == 0)) else $error("nonzero failed result");
endmodule

bind affine_2d_inverse a2i_chk u_a2i_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
`default_nettype wire
